FILE: rtl/pbr_pkg.sv
// Package for the pairwise bearing and range core.
// Holds beat types, lane state, widths and the arctangent table; no dependencies.
`timescale 1ns / 1ps
package pbr_pkg;

   localparam int COORD_BITS    = 24;
   localparam int ANGLE_BITS    = 16;
   localparam int RANGE_BITS    = 25;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int MAG_BITS      = COORD_BITS;
   localparam int SQ_BITS       = 2 * RANGE_BITS;
   localparam int REM_BITS      = RANGE_BITS + 2;
   localparam int DP_BITS       = 64;
   localparam int ACC_BITS      = 32;
   localparam int GUARD_SHIFT   = 60 - COORD_BITS;
   localparam int DEF_STAGES    = 18;
   localparam int NUM_LANES     = 3;

   typedef struct packed {
      logic [31:0]                  sample_time;
      logic signed [COORD_BITS-1:0] own_x;
      logic signed [COORD_BITS-1:0] own_y;
      logic signed [COORD_BITS-1:0] target_x;
      logic signed [COORD_BITS-1:0] target_y;
      logic signed [COORD_BITS-1:0] projectile_x;
      logic signed [COORD_BITS-1:0] projectile_y;
   } req_type;

   typedef struct packed {
      logic [31:0]           out_time;
      logic [ANGLE_BITS-1:0] bearing_own_projectile;
      logic [RANGE_BITS-1:0] distance_own_projectile;
      logic [ANGLE_BITS-1:0] bearing_own_target;
      logic [RANGE_BITS-1:0] distance_own_target;
      logic [ANGLE_BITS-1:0] bearing_projectile_target;
      logic [RANGE_BITS-1:0] distance_projectile_target;
   } rsp_type;

   typedef struct packed {
      logic signed [DP_BITS-1:0] xc;
      logic signed [DP_BITS-1:0] yc;
      logic [ACC_BITS-1:0]       acc;
      logic [SQ_BITS-1:0]        sq;
      logic [REM_BITS-1:0]       rem;
      logic [RANGE_BITS-1:0]     root;
      logic                      zero;
   } lane_type;

   function automatic logic [ACC_BITS-1:0] atan_turn(input logic [4:0] idx);
      logic [ACC_BITS-1:0] r;
      case (idx)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/pbr_prep.sv
// Lane front end: difference vector, squares, CORDIC pre-rotation, sum of squares.
// Three register stages; depends on pbr_pkg.
`timescale 1ns / 1ps
module pbr_prep (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [pbr_pkg::COORD_BITS-1:0] from_x,
   input  logic signed [pbr_pkg::COORD_BITS-1:0] from_y,
   input  logic signed [pbr_pkg::COORD_BITS-1:0] to_x,
   input  logic signed [pbr_pkg::COORD_BITS-1:0] to_y,
   output pbr_pkg::lane_type                    lane_out
);

   logic signed [pbr_pkg::DIFF_BITS-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [pbr_pkg::DIFF_BITS-1:0]        ax, ay;
   logic [2*pbr_pkg::MAG_BITS-1:0]       ax2_ff, ay2_ff, ax2_in, ay2_in;
   pbr_pkg::lane_type                    s2_ff, s2_in, s3_ff, s3_in;
   logic signed [pbr_pkg::DP_BITS-1:0]   xc0, yc0;

   always_comb begin
      dx_in = pbr_pkg::DIFF_BITS'(to_x) - pbr_pkg::DIFF_BITS'(from_x);
      dy_in = pbr_pkg::DIFF_BITS'(to_y) - pbr_pkg::DIFF_BITS'(from_y);
   end

   always_comb begin
      ax = dx_ff[pbr_pkg::DIFF_BITS-1] ? -dx_ff : dx_ff;
      ay = dy_ff[pbr_pkg::DIFF_BITS-1] ? -dy_ff : dy_ff;
      ax2_in = ax[pbr_pkg::MAG_BITS-1:0] * ax[pbr_pkg::MAG_BITS-1:0];
      ay2_in = ay[pbr_pkg::MAG_BITS-1:0] * ay[pbr_pkg::MAG_BITS-1:0];
      xc0 = pbr_pkg::DP_BITS'(dy_ff) <<< pbr_pkg::GUARD_SHIFT;
      yc0 = pbr_pkg::DP_BITS'(dx_ff) <<< pbr_pkg::GUARD_SHIFT;
      s2_in = '0;
      s2_in.zero = (dx_ff == '0) && (dy_ff == '0);
      if (dy_ff[pbr_pkg::DIFF_BITS-1]) begin
         s2_in.xc  = -xc0;
         s2_in.yc  = -yc0;
         s2_in.acc = {1'b1, {(pbr_pkg::ACC_BITS-1){1'b0}}};
      end else begin
         s2_in.xc  = xc0;
         s2_in.yc  = yc0;
      end
   end

   always_comb begin
      s3_in    = s2_ff;
      s3_in.sq = pbr_pkg::SQ_BITS'(ax2_ff) + pbr_pkg::SQ_BITS'(ay2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         ax2_ff <= ax2_in;
         ay2_ff <= ay2_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
      end
   end

   assign lane_out = s3_ff;

endmodule

FILE: rtl/pbr_cell.sv
// One cell of the lane chain: one CORDIC vectoring step if STAGE < CORDIC_STAGES,
// one square-root digit if STAGE < RANGE_BITS. Depends on pbr_pkg.
`timescale 1ns / 1ps
module pbr_cell #(
   parameter int STAGE         = 0,
   parameter int CORDIC_STAGES = pbr_pkg::DEF_STAGES
) (
   input  logic              clock,
   input  logic              en,
   input  pbr_pkg::lane_type lane_in,
   output pbr_pkg::lane_type lane_out
);

   localparam bit DO_CORDIC = (STAGE < CORDIC_STAGES) && (STAGE < 32);
   localparam bit DO_SQRT   = STAGE < pbr_pkg::RANGE_BITS;
   localparam int SHIFT     = DO_CORDIC ? STAGE : 0;
   localparam int SQ_J      = DO_SQRT ? pbr_pkg::RANGE_BITS - 1 - STAGE : 0;
   localparam logic [4:0] ATAN_IDX = 5'(SHIFT);

   pbr_pkg::lane_type                  lane_ff, next_lane_in;
   logic signed [pbr_pkg::DP_BITS-1:0] xs, ys;
   logic [pbr_pkg::REM_BITS-1:0]       rem_sh, trial;

   always_comb begin
      next_lane_in = lane_in;
      xs     = lane_in.xc >>> SHIFT;
      ys     = lane_in.yc >>> SHIFT;
      rem_sh = {lane_in.rem[pbr_pkg::REM_BITS-3:0], lane_in.sq[2*SQ_J+1 -: 2]};
      trial  = {lane_in.root, 2'b01};
      if (DO_CORDIC) begin
         if (!lane_in.yc[pbr_pkg::DP_BITS-1]) begin
            next_lane_in.xc  = lane_in.xc + ys;
            next_lane_in.yc  = lane_in.yc - xs;
            next_lane_in.acc = lane_in.acc + pbr_pkg::atan_turn(ATAN_IDX);
         end else begin
            next_lane_in.xc  = lane_in.xc - ys;
            next_lane_in.yc  = lane_in.yc + xs;
            next_lane_in.acc = lane_in.acc - pbr_pkg::atan_turn(ATAN_IDX);
         end
      end
      if (DO_SQRT) begin
         if (rem_sh >= trial) begin
            next_lane_in.rem  = rem_sh - trial;
            next_lane_in.root = {lane_in.root[pbr_pkg::RANGE_BITS-2:0], 1'b1};
         end else begin
            next_lane_in.rem  = rem_sh;
            next_lane_in.root = {lane_in.root[pbr_pkg::RANGE_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= next_lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

FILE: rtl/pairwise_bearing_range_core.sv
// Pairwise bearing and range core, top level.
// Instantiates pbr_prep and the pbr_cell chain for three lanes; depends on pbr_pkg.
//
// Usage:
//   req_valid/req_ready/req_data carry one sample beat: timestamp and X/Y of own
//   platform, target and projectile. rsp_valid/rsp_ready/rsp_data carry one result
//   beat per sample: timestamp, then bearing and range for own->projectile,
//   own->target and projectile->target.
//   Throughput: one beat per cycle while rsp_ready does not stall. The accepting
//   edge loads the first of three front-end stages; a beat then passes one cell
//   per CORDIC step or square-root digit, whichever chain is longer, and the
//   output register, which drives rsp_valid.
//   Each lane is a row of pbr_cell cells; a cell does one CORDIC rotation if its
//   index < CORDIC_STAGES, one range-root digit if index < 25; passes its state on.
//   A stalled rsp_ready holds the whole pipeline; req_ready drops while the
//   output register is full and not being taken.
//   Reset clears all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps
module pairwise_bearing_range_core #(
   parameter int CORDIC_STAGES = pbr_pkg::DEF_STAGES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pbr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pbr_pkg::rsp_type rsp_data
);

   localparam int CELLS = (CORDIC_STAGES > pbr_pkg::RANGE_BITS) ?
                          CORDIC_STAGES : pbr_pkg::RANGE_BITS;
   localparam int DEPTH = 3 + CELLS;
   localparam logic [pbr_pkg::ACC_BITS-1:0] ANGLE_RND =
      pbr_pkg::ACC_BITS'(1) << (31 - pbr_pkg::ANGLE_BITS);

   logic                         en;
   logic [DEPTH-1:0]             valid_ff, valid_in;
   logic [31:0]                  time_ff [DEPTH];
   logic                         rsp_valid_ff, rsp_valid_in;
   pbr_pkg::rsp_type             rsp_ff, rsp_in;
   pbr_pkg::lane_type            chain [pbr_pkg::NUM_LANES][CELLS+1];
   logic [pbr_pkg::ANGLE_BITS-1:0] brg [pbr_pkg::NUM_LANES];
   logic [pbr_pkg::RANGE_BITS-1:0] rng [pbr_pkg::NUM_LANES];
   logic [pbr_pkg::ACC_BITS-1:0]   acc_r [pbr_pkg::NUM_LANES];

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   pbr_prep u_prep_op (
      .clock(clock), .en(en),
      .from_x(req_data.own_x), .from_y(req_data.own_y),
      .to_x(req_data.projectile_x), .to_y(req_data.projectile_y),
      .lane_out(chain[0][0])
   );

   pbr_prep u_prep_ot (
      .clock(clock), .en(en),
      .from_x(req_data.own_x), .from_y(req_data.own_y),
      .to_x(req_data.target_x), .to_y(req_data.target_y),
      .lane_out(chain[1][0])
   );

   pbr_prep u_prep_pt (
      .clock(clock), .en(en),
      .from_x(req_data.projectile_x), .from_y(req_data.projectile_y),
      .to_x(req_data.target_x), .to_y(req_data.target_y),
      .lane_out(chain[2][0])
   );

   for (genvar l = 0; l < pbr_pkg::NUM_LANES; l++) begin : g_lane
      for (genvar k = 0; k < CELLS; k++) begin : g_cell
         pbr_cell #(
            .STAGE(k),
            .CORDIC_STAGES(CORDIC_STAGES)
         ) u_cell (
            .clock(clock),
            .en(en),
            .lane_in(chain[l][k]),
            .lane_out(chain[l][k+1])
         );
      end
   end

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], req_valid};
      rsp_valid_in = valid_ff[DEPTH-1];
      for (int l = 0; l < pbr_pkg::NUM_LANES; l++) begin
         acc_r[l] = chain[l][CELLS].acc + ANGLE_RND;
         brg[l] = chain[l][CELLS].zero ? '0 :
                  acc_r[l][pbr_pkg::ACC_BITS-1 -: pbr_pkg::ANGLE_BITS];
         rng[l] = chain[l][CELLS].root +
                  pbr_pkg::RANGE_BITS'(chain[l][CELLS].rem >
                                       pbr_pkg::REM_BITS'(chain[l][CELLS].root));
      end
      rsp_in.out_time                   = time_ff[DEPTH-1];
      rsp_in.bearing_own_projectile     = brg[0];
      rsp_in.distance_own_projectile    = rng[0];
      rsp_in.bearing_own_target         = brg[1];
      rsp_in.distance_own_target        = rng[1];
      rsp_in.bearing_projectile_target  = brg[2];
      rsp_in.distance_projectile_target = rng[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         time_ff[0] <= req_data.sample_time;
         for (int k = 1; k < DEPTH; k++) begin
            time_ff[k] <= time_ff[k-1];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: bench/tb_pairwise_bearing_range_core.sv
// Testbench for pairwise_bearing_range_core: directed table then random samples,
// each result beat checked against an in-bench CORDIC bearing and exact-range predictor.
// Depends on pbr_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_pairwise_bearing_range_core;

   localparam int STAGES    = pbr_pkg::DEF_STAGES;
   localparam int N_RANDOM  = 400;
   localparam int LATENCY   = 4 + ((STAGES > 25) ? STAGES : 25);
   localparam int N_DIRECT  = 14;
   localparam logic [pbr_pkg::RANGE_BITS-1:0] RANGE_TOP = {pbr_pkg::RANGE_BITS{1'b1}};
   localparam logic signed [pbr_pkg::COORD_BITS-1:0] CMAX =
      {1'b0, {(pbr_pkg::COORD_BITS-1){1'b1}}};
   localparam logic signed [pbr_pkg::COORD_BITS-1:0] CMIN =
      {1'b1, {(pbr_pkg::COORD_BITS-1){1'b0}}};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pbr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pbr_pkg::rsp_type rsp_data;

   pbr_pkg::rsp_type pending_results[$];
   int      n_fail = 0;
   int      n_checked = 0;
   int      stall_left = 0;
   bit      quiet_phase = 1'b0;
   bit      stim_done = 1'b0;

   always #1 clock = ~clock;

   pairwise_bearing_range_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   function automatic logic [pbr_pkg::ANGLE_BITS-1:0] cordic_bearing(longint dx,
                                                                     longint dy);
      longint xc, yc, xs, ys;
      logic [pbr_pkg::ACC_BITS-1:0] acc;
      logic [pbr_pkg::ACC_BITS-1:0] step;
      if (dx == 0 && dy == 0) return '0;
      xc = dy <<< pbr_pkg::GUARD_SHIFT;
      yc = dx <<< pbr_pkg::GUARD_SHIFT;
      acc = '0;
      if (xc < 0) begin
         xc = -xc;
         yc = -yc;
         acc = 32'h8000_0000;
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         xs = xc >>> i;
         ys = yc >>> i;
         step = pbr_pkg::atan_turn(i[4:0]);
         if (yc >= 0) begin
            xc = xc + ys;
            yc = yc - xs;
            acc = acc + step;
         end else begin
            xc = xc - ys;
            yc = yc + xs;
            acc = acc - step;
         end
      end
      acc = acc + (32'd1 << (31 - pbr_pkg::ANGLE_BITS));
      return acc[pbr_pkg::ACC_BITS-1 -: pbr_pkg::ANGLE_BITS];
   endfunction

   function automatic logic [pbr_pkg::RANGE_BITS-1:0] exact_range(longint dx, longint dy);
      longint unsigned ax, ay, s, r, lo, hi, mid;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax > RANGE_TOP || ay > RANGE_TOP) return RANGE_TOP;
      s = ax * ax + ay * ay;
      lo = 0;
      hi = 64'd1 << 26;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= s) lo = mid; else hi = mid;
      end
      r = lo;
      if (s > r * r + r) r++;
      if (r > RANGE_TOP) r = RANGE_TOP;
      return r[pbr_pkg::RANGE_BITS-1:0];
   endfunction

   function automatic pbr_pkg::rsp_type predict_sample(pbr_pkg::req_type q);
      pbr_pkg::rsp_type p;
      longint ox, oy, tx, ty, px, py;
      ox = q.own_x; oy = q.own_y;
      tx = q.target_x; ty = q.target_y;
      px = q.projectile_x; py = q.projectile_y;
      p.out_time = q.sample_time;
      p.bearing_own_projectile     = cordic_bearing(px - ox, py - oy);
      p.distance_own_projectile    = exact_range(px - ox, py - oy);
      p.bearing_own_target         = cordic_bearing(tx - ox, ty - oy);
      p.distance_own_target        = exact_range(tx - ox, ty - oy);
      p.bearing_projectile_target  = cordic_bearing(tx - px, ty - py);
      p.distance_projectile_target = exact_range(tx - px, ty - py);
      return p;
   endfunction

   function automatic pbr_pkg::req_type random_sample();
      pbr_pkg::req_type q;
      int mode;
      q = '0;
      q.sample_time = $urandom;
      mode = $urandom_range(0, 3);
      case (mode)
         0: begin
            q.own_x = pbr_pkg::COORD_BITS'($urandom);
            q.own_y = pbr_pkg::COORD_BITS'($urandom);
            q.target_x = pbr_pkg::COORD_BITS'($urandom);
            q.target_y = pbr_pkg::COORD_BITS'($urandom);
            q.projectile_x = pbr_pkg::COORD_BITS'($urandom);
            q.projectile_y = pbr_pkg::COORD_BITS'($urandom);
         end
         1: begin
            q.own_x = pbr_pkg::COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
            q.own_y = pbr_pkg::COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
            q.target_x = pbr_pkg::COORD_BITS'(q.own_x + $signed($urandom_range(0, 64)) - 32);
            q.target_y = pbr_pkg::COORD_BITS'(q.own_y + $signed($urandom_range(0, 64)) - 32);
            q.projectile_x = pbr_pkg::COORD_BITS'(q.own_x + $signed($urandom_range(0, 8)) - 4);
            q.projectile_y = pbr_pkg::COORD_BITS'(q.own_y + $signed($urandom_range(0, 8)) - 4);
         end
         2: begin
            q.own_x = $urandom_range(0, 1) ? CMAX : CMIN;
            q.own_y = $urandom_range(0, 1) ? CMAX : CMIN;
            q.target_x = $urandom_range(0, 1) ? CMAX : CMIN;
            q.target_y = $urandom_range(0, 1) ? CMAX : CMIN;
            q.projectile_x = pbr_pkg::COORD_BITS'($urandom);
            q.projectile_y = pbr_pkg::COORD_BITS'($urandom);
         end
         default: begin
            q.own_x = pbr_pkg::COORD_BITS'($urandom);
            q.own_y = pbr_pkg::COORD_BITS'($urandom);
            q.target_x = q.own_x;
            q.target_y = pbr_pkg::COORD_BITS'(q.own_y +
                                              $signed($urandom_range(0, 200000)) - 100000);
            q.projectile_x = pbr_pkg::COORD_BITS'(q.own_x +
                                                  $signed($urandom_range(0, 200000)) - 100000);
            q.projectile_y = q.own_y;
         end
      endcase
      return q;
   endfunction

   // called at a falling edge; valid is left high for a following beat
   task automatic send_sample(pbr_pkg::req_type q, bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_data  <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_sample(q));
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (quiet_phase) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pbr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_data);
            n_fail++;
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (rsp_data.out_time !== want.out_time) begin
               $error("out_time exp %0d got %0d", want.out_time, rsp_data.out_time);
               n_fail++;
            end
            if (rsp_data.bearing_own_projectile !== want.bearing_own_projectile) begin
               $error("bearing_own_projectile exp %0d got %0d",
                      want.bearing_own_projectile, rsp_data.bearing_own_projectile);
               n_fail++;
            end
            if (rsp_data.distance_own_projectile !== want.distance_own_projectile) begin
               $error("distance_own_projectile exp %0d got %0d",
                      want.distance_own_projectile, rsp_data.distance_own_projectile);
               n_fail++;
            end
            if (rsp_data.bearing_own_target !== want.bearing_own_target) begin
               $error("bearing_own_target exp %0d got %0d",
                      want.bearing_own_target, rsp_data.bearing_own_target);
               n_fail++;
            end
            if (rsp_data.distance_own_target !== want.distance_own_target) begin
               $error("distance_own_target exp %0d got %0d",
                      want.distance_own_target, rsp_data.distance_own_target);
               n_fail++;
            end
            if (rsp_data.bearing_projectile_target !== want.bearing_projectile_target) begin
               $error("bearing_projectile_target exp %0d got %0d",
                      want.bearing_projectile_target, rsp_data.bearing_projectile_target);
               n_fail++;
            end
            if (rsp_data.distance_projectile_target !== want.distance_projectile_target)
            begin
               $error("distance_projectile_target exp %0d got %0d",
                      want.distance_projectile_target, rsp_data.distance_projectile_target);
               n_fail++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      pbr_pkg::req_type directed[N_DIRECT];
      bit               typed[N_DIRECT];
      pbr_pkg::rsp_type typed_rsp[N_DIRECT];
      pbr_pkg::rsp_type p;
      pbr_pkg::req_type q;
      int               guard;

      // time, own x/y, target x/y, projectile x/y
      directed[0]  = '{32'h0, 0, 0, 0, 0, 0, 0};
      directed[1]  = '{32'hFFFF_FFFF, 0, 0, 0, 8, 8, 0};
      directed[2]  = '{32'h1234_5678, 0, 0, 0, -8, -8, 0};
      directed[3]  = '{32'h8000_0000, 0, 0, 3, 4, -3, -4};
      directed[4]  = '{32'd5, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN};
      directed[5]  = '{32'd6, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX};
      directed[6]  = '{32'd7, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN};
      directed[7]  = '{32'd8, 100, 100, 101, 100, 100, 101};
      directed[8]  = '{32'd9, 0, 0, 1, -1, -1, 1};
      directed[9]  = '{32'd10, 0, 0, -1, 0, 0, -1};
      directed[10] = '{32'd11, 5, 5, 5, 6, 4, 5};
      directed[11] = '{32'd12, CMIN, 0, CMAX, 0, 0, CMAX};
      directed[12] = '{32'd13, 0, CMIN, 0, CMAX, 1, 0};
      directed[13] = '{32'hA5A5_5A5A, -1, -1, 1, 1, -1, 1};

      foreach (typed[i]) typed[i] = 1'b0;
      typed[0] = 1'b1;
      typed_rsp[0] = '{32'h0, 16'd0, 25'd0, 16'd0, 25'd0, 16'd0, 25'd0};
      // compass points and diagonals
      typed[1] = 1'b1;
      typed_rsp[1] = '{32'hFFFF_FFFF, 16'h4000, 25'd8, 16'h0000, 25'd8, 16'hE000, 25'd11};
      typed[2] = 1'b1;
      typed_rsp[2] = '{32'h1234_5678, 16'hC000, 25'd8, 16'h8000, 25'd8, 16'h6000, 25'd11};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECT; i++) begin
         p = predict_sample(directed[i]);
         if (typed[i]) begin
            if (p.bearing_own_projectile !== typed_rsp[i].bearing_own_projectile
                || p.distance_own_projectile !== typed_rsp[i].distance_own_projectile
                || p.bearing_own_target !== typed_rsp[i].bearing_own_target
                || p.distance_own_target !== typed_rsp[i].distance_own_target
                || p.bearing_projectile_target !== typed_rsp[i].bearing_projectile_target
                || p.distance_projectile_target !== typed_rsp[i].distance_projectile_target)
            begin
               $error("predictor disagrees with table row %0d", i);
               n_fail++;
            end
         end
         send_sample(directed[i], 1'b1);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - 60) quiet_phase = 1'b1;
         q = random_sample();
         send_sample(q, !quiet_phase);
      end
      req_valid <= 1'b0;
      quiet_phase = 1'b1;

      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 5) @(posedge clock);

      $display("Covered %0d samples (%0d directed), %0d result beats checked.",
               N_DIRECT + N_RANDOM, N_DIRECT, n_checked);
      if (n_fail == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures, %0d outstanding", n_fail, pending_results.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
